@@ src/irf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irf_pkg
// Shared types and constants for the integer radix formatter: character
// codes, radix codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package irf_pkg;

  // field widths fixed by the interface
  localparam int CHAR_W  = 16;
  localparam int WIDTH_W = 7;
  localparam int RADIX_W = 2;
  localparam int DIGIT_W = 4;

  // radix select codes
  localparam logic [RADIX_W-1:0] RADIX_BIN = 2'd0;
  localparam logic [RADIX_W-1:0] RADIX_OCT = 2'd1;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 2'd2;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 2'd3;

  // character codes
  localparam logic [CHAR_W-1:0] CH_ZERO       = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_ALPHA_BASE = 16'h0037;
  localparam logic [CHAR_W-1:0] CH_MINUS      = 16'h002D;
  localparam logic [CHAR_W-1:0] CH_PLUS       = 16'h002B;
  localparam logic [CHAR_W-1:0] CH_SPACE      = 16'h0020;

  // digit values at or above this get the letter offset
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_PREP,
    S_PAD,
    S_SIGN,
    S_DIGIT
  } irf_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic prep;
    logic emit_pad;
    logic emit_sign;
    logic emit_digit;
  } irf_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic conv_last;
    logic pad_zero;
    logic has_sign;
    logic digit_last;
  } irf_sts_t;

endpackage

@@ src/integer_radix_formatter.sv @@
`timescale 1ns / 1ps
// after conversion and length preparation the first character is registered from the pad state
// or, with no pad run, the sign or digit state; later while the previous last word is stalled
// conversion runs one value bit per cycle through the shift-and-adjust digit row
// then one character per cycle while the output side takes them, with a gap after a pad run
// a new item is accepted only in idle, after the last digit of the previous one is emitted
// reset: synchronous active-low rst_n clears the controller state and output valid
// ----------------------------------------------------------------------------
// integer_radix_formatter
// Prints a signed integer in radix 2, 8, 10 or 16 as a stream of 16-bit
// characters: left pad run, optional sign, uppercase digits, last marker.
// ----------------------------------------------------------------------------
module integer_radix_formatter import irf_pkg::*; #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_WIDTH  = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic [RADIX_W-1:0]           in_radix_select,
  input  logic                         in_width_given,
  input  logic [WIDTH_W-1:0]           in_min_width,
  input  logic [CHAR_W-1:0]            in_pad_char,
  input  logic                         in_force_sign,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [CHAR_W-1:0]            out_char_code,
  output logic                         out_last_char
);

  irf_cmd_t cmd;
  irf_sts_t sts;

  // sequencer
  irf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // conversion and output datapath
  irf_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .in_value        (in_value),
    .in_radix_select (in_radix_select),
    .in_width_given  (in_width_given),
    .in_min_width    (in_min_width),
    .in_pad_char     (in_pad_char),
    .in_force_sign   (in_force_sign),
    .sts             (sts),
    .out_char_code   (out_char_code),
    .out_last_char   (out_last_char)
  );

endmodule

@@ src/irf_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irf_dp
// Formatter datapath: magnitude shift register, radix digit row converted
// one bit per cycle with a shift-and-adjust step, pad and digit counters and
// the output word register.
// ----------------------------------------------------------------------------
module irf_dp import irf_pkg::*; #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_WIDTH  = 64
) (
  input  logic                      clk,
  input  irf_cmd_t                  cmd,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic [RADIX_W-1:0]        in_radix_select,
  input  logic                      in_width_given,
  input  logic [WIDTH_W-1:0]        in_min_width,
  input  logic [CHAR_W-1:0]         in_pad_char,
  input  logic                      in_force_sign,
  output irf_sts_t                  sts,
  output logic [CHAR_W-1:0]         out_char_code,
  output logic                      out_last_char
);

  // binary needs one digit per value bit, every other radix needs fewer
  localparam int NDIG = VALUE_BITS;
  localparam int DIW  = $clog2(NDIG + 1);
  localparam int IDXW = $clog2(NDIG);
  localparam int BCW  = $clog2(VALUE_BITS + 1);
  localparam logic [WIDTH_W-1:0] WIDTH_CAP = WIDTH_W'(MAX_WIDTH);

  logic [VALUE_BITS-1:0]          mag_r, mag_nxt;
  logic [NDIG-1:0][DIGIT_W-1:0]   digits_r, digits_nxt;
  logic [DIW-1:0]                 ndig_r, ndig_nxt;
  logic [BCW-1:0]                 bit_cnt_r, bit_cnt_nxt;
  logic [RADIX_W-1:0]             radix_r, radix_nxt;
  logic [CHAR_W-1:0]              pad_char_r, pad_char_nxt;
  logic                           has_sign_r, has_sign_nxt;
  logic                           neg_r, neg_nxt;
  logic [WIDTH_W-1:0]             width_r, width_nxt;
  logic [WIDTH_W-1:0]             pad_cnt_r, pad_cnt_nxt;
  logic [IDXW-1:0]                dig_idx_r, dig_idx_nxt;
  logic [CHAR_W-1:0]              out_char_r, out_char_nxt;
  logic                           out_last_r, out_last_nxt;

  logic [VALUE_BITS-1:0]          raw;
  logic [VALUE_BITS-1:0]          mag_in;
  logic                           neg_in;
  logic [WIDTH_W-1:0]             width_sat;
  logic [DIGIT_W-1:0]             half;
  logic [DIGIT_W-1:0]             addv;
  logic [NDIG-1:0][DIGIT_W-1:0]   adj;
  logic [NDIG-1:0][DIGIT_W-1:0]   stepped;
  logic [NDIG-1:0]                carry;
  logic                           grow;
  logic [WIDTH_W-1:0]             text_len;
  logic [DIGIT_W-1:0]             cur_digit;
  logic [CHAR_W-1:0]              digit_char;

  // input decode: magnitude, sign and saturated width
  assign raw       = in_value;
  assign neg_in    = raw[VALUE_BITS-1];
  assign mag_in    = neg_in ? VALUE_BITS'(~raw + 1'b1) : raw;
  assign width_sat = (in_min_width > WIDTH_CAP) ? WIDTH_CAP : in_min_width;

  // adjust constants: pre-shift add that makes bit 3 the carry into the next digit
  always_comb begin
    unique case (radix_r)
      RADIX_BIN: begin
        half = 4'd1;
        addv = 4'd7;
      end
      RADIX_OCT: begin
        half = 4'd4;
        addv = 4'd4;
      end
      RADIX_DEC: begin
        half = 4'd5;
        addv = 4'd3;
      end
      RADIX_HEX: begin
        half = 4'd8;
        addv = 4'd0;
      end
    endcase
  end

  // one conversion step: adjust every digit, then shift the row left one bit
  always_comb begin
    grow = 1'b0;
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (digits_r[i] >= half) ? digits_r[i] + addv : digits_r[i];
    end
    carry[0] = mag_r[VALUE_BITS-1];
    for (int i = 1; i < NDIG; i++) begin
      carry[i] = adj[i-1][DIGIT_W-1];
    end
    for (int i = 0; i < NDIG; i++) begin
      stepped[i] = {adj[i][DIGIT_W-2:0], carry[i]};
    end
    // the digit count rises by at most one per doubling
    for (int i = 0; i < NDIG; i++) begin
      if ((DIW'(i) == ndig_r) && (stepped[i] != '0)) begin
        grow = 1'b1;
      end
    end
  end

  // text length: at least one digit, plus the sign
  assign text_len = ((ndig_r == '0) ? WIDTH_W'(1) : WIDTH_W'(ndig_r)) + WIDTH_W'(has_sign_r);

  // current digit to character
  assign cur_digit  = digits_r[dig_idx_r];
  assign digit_char = (cur_digit < DIGIT_TEN) ? CHAR_W'(cur_digit) + CH_ZERO
                                              : CHAR_W'(cur_digit) + CH_ALPHA_BASE;

  // next-state logic for the datapath registers
  always_comb begin
    mag_nxt      = mag_r;
    digits_nxt   = digits_r;
    ndig_nxt     = ndig_r;
    bit_cnt_nxt  = bit_cnt_r;
    radix_nxt    = radix_r;
    pad_char_nxt = pad_char_r;
    has_sign_nxt = has_sign_r;
    neg_nxt      = neg_r;
    width_nxt    = width_r;
    pad_cnt_nxt  = pad_cnt_r;
    dig_idx_nxt  = dig_idx_r;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;

    if (cmd.load) begin
      mag_nxt      = mag_in;
      digits_nxt   = '0;
      ndig_nxt     = '0;
      bit_cnt_nxt  = BCW'(VALUE_BITS);
      radix_nxt    = in_radix_select;
      pad_char_nxt = in_pad_char;
      has_sign_nxt = (raw != '0) && (neg_in || in_force_sign);
      neg_nxt      = neg_in;
      width_nxt    = in_width_given ? width_sat : '0;
    end

    if (cmd.conv_step) begin
      mag_nxt     = {mag_r[VALUE_BITS-2:0], 1'b0};
      digits_nxt  = stepped;
      ndig_nxt    = ndig_r + DIW'(grow);
      bit_cnt_nxt = bit_cnt_r - 1'b1;
    end

    if (cmd.prep) begin
      pad_cnt_nxt = (width_r > text_len) ? width_r - text_len : '0;
      dig_idx_nxt = (ndig_r == '0) ? '0 : IDXW'(ndig_r - 1'b1);
    end

    if (cmd.emit_pad) begin
      pad_cnt_nxt  = pad_cnt_r - 1'b1;
      out_char_nxt = pad_char_r;
      out_last_nxt = 1'b0;
    end

    if (cmd.emit_sign) begin
      out_char_nxt = neg_r ? CH_MINUS : CH_PLUS;
      out_last_nxt = 1'b0;
    end

    if (cmd.emit_digit) begin
      dig_idx_nxt  = dig_idx_r - 1'b1;
      out_char_nxt = digit_char;
      out_last_nxt = (dig_idx_r == '0);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    digits_r   <= digits_nxt;
    ndig_r     <= ndig_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    radix_r    <= radix_nxt;
    pad_char_r <= pad_char_nxt;
    has_sign_r <= has_sign_nxt;
    neg_r      <= neg_nxt;
    width_r    <= width_nxt;
    pad_cnt_r  <= pad_cnt_nxt;
    dig_idx_r  <= dig_idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // status back to the controller
  assign sts.conv_last  = (bit_cnt_r == BCW'(1));
  assign sts.pad_zero   = (pad_cnt_r == '0);
  assign sts.has_sign   = has_sign_r;
  assign sts.digit_last = (dig_idx_r == '0);

  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

endmodule

@@ src/irf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irf_ctrl
// Formatter controller: sequences load, conversion, pad/sign/digit emission
// and owns the input stall and the output word valid flag.
// ----------------------------------------------------------------------------
module irf_ctrl import irf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  irf_sts_t sts,
  output irf_cmd_t cmd
);

  irf_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       out_take;
  logic       emit;

  // output register can take a new word this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign out_take = out_valid_r && !out_stall;
  assign emit     = cmd.emit_pad || cmd.emit_sign || cmd.emit_digit;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CONV;
      end
      S_CONV: begin
        if (sts.conv_last) state_nxt = S_PREP;
      end
      S_PREP: begin
        state_nxt = S_PAD;
      end
      S_PAD: begin
        if (sts.pad_zero) state_nxt = sts.has_sign ? S_SIGN : S_DIGIT;
      end
      S_SIGN: begin
        if (out_free) state_nxt = S_DIGIT;
      end
      S_DIGIT: begin
        if (out_free && sts.digit_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
      end
      S_PAD: begin
        cmd.emit_pad = !sts.pad_zero && out_free;
      end
      S_SIGN: begin
        cmd.emit_sign = out_free;
      end
      S_DIGIT: begin
        cmd.emit_digit = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a held word is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !emit)
    else $error("irf_ctrl: word emitted while output is stalled");

  // an accepted item always starts conversion
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_CONV))
    else $error("irf_ctrl: load did not start conversion");

  // conversion hands over to length preparation
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV && sts.conv_last) |=> (state_r == S_PREP))
    else $error("irf_ctrl: conversion did not end in prep");

  // the final digit returns to idle with a valid word waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_digit && sts.digit_last) |=> (state_r == S_IDLE && out_valid_r))
    else $error("irf_ctrl: final digit did not close the item");

endmodule
